// ===== design/cpff_pkg.sv =====
// Package with the shared types, codes and sizes of the command packet filter FIFO.
`default_nettype none

package cpff_pkg;

  localparam int QueueDepth = 4;
  localparam int IdxW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW       = $clog2(QueueDepth + 1);

  localparam logic [7:0] SenderId   = 8'd1;
  localparam logic [7:0] TargetId   = 8'd2;
  localparam logic [7:0] RoomMin    = 8'd1;
  localparam logic [7:0] RoomMax    = 8'd8;
  localparam logic [7:0] RoomStartA = 8'd3;
  localparam logic [7:0] RoomStartB = 8'd4;

  localparam logic [7:0] HeaderReset  = 8'd165;
  localparam logic [7:0] TargetReset  = 8'd1;
  localparam logic [7:0] StartReset   = 8'd2;
  localparam logic [7:0] ReleaseReset = 8'd3;

  typedef enum logic [1:0] {
    REQ_PACKET     = 2'd0,
    REQ_POP        = 2'd1,
    REQ_CLEAR      = 2'd2,
    REQ_POP_TARGET = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_FULL       = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_NOT_TARGET = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_HEADER  = 2'd0,
    CFG_TARGET  = 2'd1,
    CFG_START   = 2'd2,
    CFG_RELEASE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] in_header;
    logic [7:0] in_sender;
    logic [7:0] in_target;
    logic [7:0] in_cmd;
    logic [7:0] in_room;
    logic [7:0] in_seq;
    logic [7:0] in_reserved;
    logic [7:0] in_checksum;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_sender;
    logic [7:0] out_target;
    logic [7:0] out_cmd;
    logic [7:0] out_room;
    logic [7:0] out_seq;
    logic [3:0] saved_room;
    logic [2:0] pending_count;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] sender;
    logic [7:0] target;
    logic [7:0] cmd;
    logic [7:0] room;
    logic [7:0] seq;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== design/command_packet_filter_fifo.sv =====
// Top level of the command packet filter with its receive FIFO.
//
//  Channel   Direction  Handshake                     Payload
//  in        input      in_valid_i / in_stall_o       in_data_i  (cpff_pkg::in_beat_t)
//  out       output     out_valid_o / out_stall_i     out_data_o (cpff_pkg::out_beat_t)
//  cfg       input      cfg_we_i                      cfg_idx_i, cfg_wdata_i
//
// Each beat goes through capture, execute for the check and FIFO update, and
// presentation of the result.
// The controller handles one beat at a time; a new beat is taken once the result is taken.
// A stall on the output holds the result and keeps the input stalled.
// Reset empties the FIFO, clears the saved room and loads the default command codes.
`default_nettype none

module command_packet_filter_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire cpff_pkg::in_beat_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output cpff_pkg::out_beat_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [7:0]          cfg_wdata_i
);

  cpff_pkg::dp_cmd_t dp_cmd;

  cpff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd)
  );

  cpff_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== design/cpff_ctrl.sv =====
// Controller state machine that sequences capture, execution and output of one beat.
`default_nettype none

module cpff_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output cpff_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.execute = (state_q == S_EXEC);

`ifndef ASSERT_OFF
  a_exec_follows_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.execute)
    else $error("execute did not follow a captured beat");
  a_exec_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> out_valid_o)
    else $error("result not presented after execute");
  a_no_capture_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !cmd_o.capture)
    else $error("input captured while a result is pending");
`endif

endmodule

`default_nettype wire

// ===== design/cpff_datapath.sv =====
// Datapath: packet checks, receive FIFO, saved room, configuration and result register.
`default_nettype none

module cpff_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cpff_pkg::dp_cmd_t   cmd_i,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [7:0]          cfg_wdata_i,
  input  wire cpff_pkg::in_beat_t  in_data_i,
  output cpff_pkg::out_beat_t      out_data_o
);

  localparam int IdxW = cpff_pkg::IdxW;
  localparam int CntW = cpff_pkg::CntW;

  cpff_pkg::entry_t    mem [cpff_pkg::QueueDepth];
  cpff_pkg::entry_t    head_q;
  cpff_pkg::in_beat_t  beat_q;
  cpff_pkg::out_beat_t out_q, out_d;

  logic [7:0]      header_q, target_code_q, start_code_q, release_code_q;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic [3:0]      saved_q, saved_d;

  logic [7:0]       xsum;
  logic             hdr_ok, pkt_ok, room_target, room_start, full, empty, do_write;
  cpff_pkg::entry_t new_entry;

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
    next_idx = (idx == IdxW'(cpff_pkg::QueueDepth - 1)) ? '0 : idx + IdxW'(1);
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q       <= cpff_pkg::HeaderReset;
      target_code_q  <= cpff_pkg::TargetReset;
      start_code_q   <= cpff_pkg::StartReset;
      release_code_q <= cpff_pkg::ReleaseReset;
    end else if (cfg_we_i) begin
      unique case (cpff_pkg::cfg_idx_e'(cfg_idx_i))
        cpff_pkg::CFG_HEADER:  header_q       <= cfg_wdata_i;
        cpff_pkg::CFG_TARGET:  target_code_q  <= cfg_wdata_i;
        cpff_pkg::CFG_START:   start_code_q   <= cfg_wdata_i;
        cpff_pkg::CFG_RELEASE: release_code_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      beat_q <= in_data_i;
    end
  end

  // Packet check.
  always_comb begin
    xsum = beat_q.in_header ^ beat_q.in_sender ^ beat_q.in_target ^ beat_q.in_cmd ^
           beat_q.in_room ^ beat_q.in_seq ^ beat_q.in_reserved;
    hdr_ok = (beat_q.in_header == header_q) && (beat_q.in_sender == cpff_pkg::SenderId) &&
             (beat_q.in_target == cpff_pkg::TargetId) && (xsum == beat_q.in_checksum);
    room_target = (beat_q.in_room >= cpff_pkg::RoomMin) &&
                  (beat_q.in_room <= cpff_pkg::RoomMax);
    room_start  = (beat_q.in_room == cpff_pkg::RoomStartA) ||
                  (beat_q.in_room == cpff_pkg::RoomStartB);
    // The target-room code takes priority when codes are programmed equal.
    if (beat_q.in_cmd == target_code_q) begin
      pkt_ok = hdr_ok && room_target;
    end else if ((beat_q.in_cmd == start_code_q) || (beat_q.in_cmd == release_code_q)) begin
      pkt_ok = hdr_ok && room_start;
    end else begin
      pkt_ok = 1'b0;
    end
  end

  assign full  = (count_q == CntW'(cpff_pkg::QueueDepth));
  assign empty = (count_q == '0);

  assign new_entry.sender = beat_q.in_sender;
  assign new_entry.target = beat_q.in_target;
  assign new_entry.cmd    = beat_q.in_cmd;
  assign new_entry.room   = beat_q.in_room;
  assign new_entry.seq    = beat_q.in_seq;

  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    count_d  = count_q;
    saved_d  = saved_q;
    do_write = 1'b0;
    out_d.status     = cpff_pkg::ST_OK;
    out_d.out_sender = '0;
    out_d.out_target = '0;
    out_d.out_cmd    = '0;
    out_d.out_room   = '0;
    out_d.out_seq    = '0;
    case (cpff_pkg::req_e'(beat_q.req_type))
      cpff_pkg::REQ_PACKET: begin
        if (!pkt_ok) begin
          out_d.status = cpff_pkg::ST_INVALID;
        end else if (full) begin
          out_d.status = cpff_pkg::ST_FULL;
        end else begin
          do_write = 1'b1;
          wr_idx_d = next_idx(wr_idx_q);
          count_d  = count_q + CntW'(1);
          if (beat_q.in_cmd == target_code_q) begin
            saved_d = beat_q.in_room[3:0];
          end
        end
      end
      cpff_pkg::REQ_CLEAR: begin
        wr_idx_d = '0;
        rd_idx_d = '0;
        count_d  = '0;
      end
      default: begin
        if (empty) begin
          out_d.status = cpff_pkg::ST_EMPTY;
        end else begin
          out_d.out_sender = head_q.sender;
          out_d.out_target = head_q.target;
          out_d.out_cmd    = head_q.cmd;
          out_d.out_room   = head_q.room;
          out_d.out_seq    = head_q.seq;
          rd_idx_d = next_idx(rd_idx_q);
          count_d  = count_q - CntW'(1);
          if (beat_q.req_type == cpff_pkg::REQ_POP_TARGET) begin
            if (head_q.cmd == target_code_q) begin
              saved_d = head_q.room[3:0];
            end else begin
              out_d.status = cpff_pkg::ST_NOT_TARGET;
            end
          end
        end
      end
    endcase
    out_d.saved_room    = saved_d;
    out_d.pending_count = 3'(count_d);
  end

  // Head entry is a registered read of the memory; the read pointer and memory settle while the
  // previous result is presented, so the head is current whenever a beat executes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && do_write) begin
      mem[wr_idx_q] <= new_entry;
    end
    head_q <= mem[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      count_q  <= '0;
      saved_q  <= '0;
    end else if (cmd_i.execute) begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      count_q  <= count_d;
      saved_q  <= saved_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(cpff_pkg::QueueDepth))
    else $error("FIFO count exceeds depth");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.execute && (beat_q.req_type == cpff_pkg::REQ_CLEAR)) |=> (count_q == '0))
    else $error("clear did not empty the FIFO");
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.execute && (out_d.status == cpff_pkg::ST_FULL)) |=>
      (count_q == CntW'(cpff_pkg::QueueDepth)) && $stable(wr_idx_q))
    else $error("dropped packet changed the FIFO");
  a_invalid_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.execute && (out_d.status == cpff_pkg::ST_INVALID)) |=>
      $stable(count_q) && $stable(saved_q))
    else $error("invalid packet changed state");
`endif

endmodule

`default_nettype wire
